// ===== src/vfhp_pkg.sv =====
// Package with the types, constants and register codes of the video fragment header parser.
`timescale 1ns / 1ps

package vfhp_pkg;

    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Byte offsets of the header fields.
    localparam logic [COUNT_BITS-1:0] OFS_VERSION = COUNT_BITS'(4);
    localparam logic [COUNT_BITS-1:0] OFS_FLAGS   = COUNT_BITS'(5);
    localparam logic [COUNT_BITS-1:0] OFS_STREAM  = COUNT_BITS'(8);
    localparam logic [COUNT_BITS-1:0] OFS_FRAME   = COUNT_BITS'(12);
    localparam logic [COUNT_BITS-1:0] OFS_FIDX    = COUNT_BITS'(16);
    localparam logic [COUNT_BITS-1:0] OFS_FCNT    = COUNT_BITS'(18);
    localparam logic [COUNT_BITS-1:0] OFS_PTS     = COUNT_BITS'(20);
    localparam logic [COUNT_BITS-1:0] HDR_BYTES   = COUNT_BITS'(24);

    localparam int CFG_INDEX_BITS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPECTED_MAGIC   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPECTED_VERSION = CFG_INDEX_BITS'(1);

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_MAGIC    = 3'd2;
    localparam logic [2:0] ST_VERSION  = 3'd3;
    localparam logic [2:0] ST_HDR_LEN  = 3'd4;
    localparam logic [2:0] ST_FRAGMENT = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        packet_end;
        logic [2:0]  status;
        logic [7:0]  hdr_flags;
        logic [31:0] stream_id;
        logic [31:0] frame_id;
        logic [15:0] frag_index;
        logic [15:0] frag_count;
        logic [31:0] pts_ms;
    } out_item_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  version_byte;
        logic [7:0]  flags_byte;
        logic [15:0] header_length;
        logic [31:0] stream_word;
        logic [31:0] frame_word;
        logic [15:0] fragment_index;
        logic [15:0] fragment_count;
        logic [31:0] timestamp_word;
    } hdr_fields_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] pos;
        logic [COUNT_BITS-1:0] len;
    } count_info_t;

endpackage

// ===== src/vfhp_capture.sv =====
// Byte counter and header field capture registers.
`timescale 1ns / 1ps

module vfhp_capture (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output vfhp_pkg::hdr_fields_t hdr,
    output vfhp_pkg::count_info_t cnt
);
    import vfhp_pkg::*;

    logic [COUNT_BITS-1:0] byte_count_reg;
    logic [COUNT_BITS-1:0] byte_count_next;
    hdr_fields_t           hdr_reg;
    hdr_fields_t           hdr_next;
    hdr_fields_t           cap;

    // The header as it stands once the current byte has been taken in.
    always_comb
    begin
        cap = hdr_reg;
        if (byte_count_reg < OFS_VERSION)
            cap.magic_word = {hdr_reg.magic_word[23:0], data_byte};
        else if (byte_count_reg == OFS_VERSION)
            cap.version_byte = data_byte;
        else if (byte_count_reg == OFS_FLAGS)
            cap.flags_byte = data_byte;
        else if (byte_count_reg < OFS_STREAM)
            cap.header_length = {hdr_reg.header_length[7:0], data_byte};
        else if (byte_count_reg < OFS_FRAME)
            cap.stream_word = {hdr_reg.stream_word[23:0], data_byte};
        else if (byte_count_reg < OFS_FIDX)
            cap.frame_word = {hdr_reg.frame_word[23:0], data_byte};
        else if (byte_count_reg < OFS_FCNT)
            cap.fragment_index = {hdr_reg.fragment_index[7:0], data_byte};
        else if (byte_count_reg < OFS_PTS)
            cap.fragment_count = {hdr_reg.fragment_count[7:0], data_byte};
        else if (byte_count_reg < HDR_BYTES)
            cap.timestamp_word = {hdr_reg.timestamp_word[23:0], data_byte};
    end

    always_comb
    begin
        cnt.pos = byte_count_reg;
        cnt.len = (byte_count_reg == COUNT_MAX) ? COUNT_MAX
                                                : byte_count_reg + COUNT_BITS'(1);
        byte_count_next = byte_count_reg;
        hdr_next        = hdr_reg;
        if (advance)
        begin
            if (last_byte)
            begin
                byte_count_next = '0;
                hdr_next        = '0;
            end
            else
            begin
                byte_count_next = cnt.len;
                hdr_next        = cap;
            end
        end
    end

    assign hdr = cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            hdr_reg        <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            hdr_reg        <= hdr_next;
        end
    end

endmodule

// ===== src/vfhp_check.sv =====
// Payload decision and packet status checks.
`timescale 1ns / 1ps

module vfhp_check (
    input  vfhp_pkg::hdr_fields_t hdr,
    input  vfhp_pkg::count_info_t cnt,
    input  logic [31:0]           expected_magic,
    input  logic [7:0]            expected_version,
    output logic                  is_payload,
    output logic [2:0]            status
);
    import vfhp_pkg::*;

    logic [COUNT_BITS-1:0] hlen_ext;

    assign hlen_ext   = COUNT_BITS'(hdr.header_length);
    assign is_payload = (cnt.pos >= HDR_BYTES) && (cnt.pos >= hlen_ext);

    always_comb
    begin
        if (cnt.len < HDR_BYTES)
            status = ST_SHORT;
        else if (hdr.magic_word != expected_magic)
            status = ST_MAGIC;
        else if (hdr.version_byte != expected_version)
            status = ST_VERSION;
        else if ((hlen_ext < HDR_BYTES) || (hlen_ext > cnt.len))
            status = ST_HDR_LEN;
        else if ((hdr.fragment_count == 16'd0) ||
                 (hdr.fragment_index >= hdr.fragment_count))
            status = ST_FRAGMENT;
        else
            status = ST_OK;
    end

endmodule

// ===== src/video_fragment_header_parser_unit.sv =====
// Top level of the video fragment header parser: input stage, capture, checks, result stage.
// An accepted byte is held in the input register, and its result is held in the result register.
// Throughput: one byte per cycle while out_stall is low; the header capture and status
// checks sit between the input register and the result register.
// Bytes in the header area produce no result unless flagged as last.
// Reset (rst_n, asynchronous, active low) clears the byte counter, header fields,
// both configuration registers and all valid flags.
`timescale 1ns / 1ps

module video_fragment_header_parser_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  vfhp_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output vfhp_pkg::out_item_t                  out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vfhp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [31:0]                          cfg_data
);
    import vfhp_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    out_item_t   result;
    logic [31:0] expected_magic_reg;
    logic [7:0]  expected_version_reg;

    logic        s1_stall;
    logic        s1_advance;
    logic        is_payload;
    logic [2:0]  status;
    hdr_fields_t hdr;
    count_info_t cnt;

    assign cfg_ready  = 1'b1;
    assign s1_stall   = out_valid_reg && out_stall;
    assign s1_advance = in_valid_reg && !s1_stall;
    assign in_stall   = in_valid_reg && s1_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_magic_reg   <= '0;
            expected_version_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_MAGIC:   expected_magic_reg   <= cfg_data;
                CFG_EXPECTED_VERSION: expected_version_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_data;
    end

    vfhp_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_advance),
        .data_byte (in_item_reg.data_byte),
        .last_byte (in_item_reg.last_byte),
        .hdr       (hdr),
        .cnt       (cnt)
    );

    vfhp_check u_check (
        .hdr              (hdr),
        .cnt              (cnt),
        .expected_magic   (expected_magic_reg),
        .expected_version (expected_version_reg),
        .is_payload       (is_payload),
        .status           (status)
    );

    // Header fields and status are reported only with the packet end.
    always_comb
    begin
        result = '0;
        if (is_payload)
        begin
            result.payload_byte  = in_item_reg.data_byte;
            result.payload_valid = 1'b1;
        end
        if (in_item_reg.last_byte)
        begin
            result.packet_end = 1'b1;
            result.status     = status;
            result.hdr_flags  = hdr.flags_byte;
            result.stream_id  = hdr.stream_word;
            result.frame_id   = hdr.frame_word;
            result.frag_index = hdr.fragment_index;
            result.frag_count = hdr.fragment_count;
            result.pts_ms     = hdr.timestamp_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && (is_payload || in_item_reg.last_byte))
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && (is_payload || in_item_reg.last_byte))
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // A transaction on the result side always carries payload, a packet end, or both.
    a_result_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.payload_valid || out_data.packet_end))
        else $error("result without payload or packet end");

    // A nonzero status only comes with the packet end.
    a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.packet_end) |-> (out_data.status == ST_OK))
        else $error("status reported away from packet end");

    // The byte counter restarts after the last byte of a packet is processed.
    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && in_item_reg.last_byte) |=> (cnt.pos == '0))
        else $error("byte counter not cleared after packet end");

    // No payload can come out of the first header bytes.
    a_no_early_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && (cnt.pos < HDR_BYTES)) |-> !is_payload)
        else $error("payload flagged inside the fixed header");

endmodule
